// ===== rtl/ube_pkg.sv =====
// ----------------------------------------------------------------------------
// ube_pkg
// Types, constants and byte-forming helpers shared by the UTF-8 encoder.
// ----------------------------------------------------------------------------
package ube_pkg;

  localparam int CpW       = 32;
  localparam int CountW    = 32;
  localparam int CfgIdxW   = 1;
  localparam int LenW      = 3;
  localparam int QueueDepth = 2;

  localparam logic [CfgIdxW-1:0] REG_BYTE_LIMIT   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT_ENABLE = 1'd1;

  localparam logic [CountW-1:0] BYTE_LIMIT_RST   = 32'hFFFF_FFFF;
  localparam logic              LIMIT_ENABLE_RST = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_STOPPED = 2'd2
  } status_e;

  // One classified character on its way from the front to the back.
  typedef struct packed {
    logic [30:0]       cp;
    logic [LenW-1:0]   len;
    status_e           status;
    logic [CountW-1:0] base;
  } desc_t;

  function automatic logic [7:0] lead_mark(logic [LenW-1:0] len);
    logic [7:0] m;
    unique case (len)
      3'd2:    m = 8'hC0;
      3'd3:    m = 8'hE0;
      3'd4:    m = 8'hF0;
      3'd5:    m = 8'hF8;
      3'd6:    m = 8'hFC;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Byte idx (0 = lead) of a character of len bytes.
  function automatic logic [7:0] enc_byte(logic [30:0] cp, logic [LenW-1:0] len,
                                          logic [LenW-1:0] idx);
    logic [39:0]     wide;
    logic [LenW-1:0] r;
    logic [7:0]      sh;
    logic [7:0]      res;
    wide = {9'd0, cp};
    r    = len - idx - 3'd1;
    unique case (r)
      3'd0:    sh = wide[7:0];
      3'd1:    sh = wide[13:6];
      3'd2:    sh = wide[19:12];
      3'd3:    sh = wide[25:18];
      3'd4:    sh = wide[31:24];
      3'd5:    sh = wide[37:30];
      default: sh = 8'h00;
    endcase
    if (len == 3'd1) begin
      res = sh;
    end else if (idx == 3'd0) begin
      res = lead_mark(len) | sh;
    end else begin
      res = 8'h80 | {2'b00, sh[5:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/ube_front.sv =====
// ----------------------------------------------------------------------------
// ube_front
// Accepts characters, applies the byte budget and halt rules, keeps the
// running count and pushes one descriptor per character into the queue.
// ----------------------------------------------------------------------------
module ube_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ube_pkg::CpW-1:0]     code_point_i,
  input  logic                        first_of_string_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ube_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ube_pkg::CountW-1:0]  cfg_data_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output ube_pkg::desc_t              push_desc_o
);

  logic [ube_pkg::CountW-1:0] byte_limit_q;
  logic                       limit_enable_q;
  logic [ube_pkg::CountW-1:0] count_q, count_d;
  logic                       halted_q, halted_d;

  logic [ube_pkg::CountW-1:0] cnt_base;
  logic                       halt_eff;
  logic                       is_ascii;
  logic [ube_pkg::LenW-1:0]   len;
  logic [ube_pkg::CountW:0]   sum;
  logic                       over;
  ube_pkg::status_e           status;
  logic                       in_fire;

  assign in_ready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  assign cnt_base = first_of_string_i ? '0 : count_q;
  assign halt_eff = first_of_string_i ? 1'b0 : halted_q;
  assign is_ascii = (code_point_i[31:7] == '0);

  always_comb begin
    priority if (is_ascii) begin
      len = 3'd1;
    end else if (code_point_i < 32'h0000_0800) begin
      len = 3'd2;
    end else if (code_point_i < 32'h0001_0000) begin
      len = 3'd3;
    end else if (code_point_i < 32'h0020_0000) begin
      len = 3'd4;
    end else if (code_point_i < 32'h0400_0000) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
  end

  assign sum = {1'b0, cnt_base} + (ube_pkg::CountW + 1)'(len);

  // A single byte needs count < limit, a longer character count + len < limit.
  always_comb begin
    if (is_ascii) begin
      over = limit_enable_q && (cnt_base >= byte_limit_q);
    end else begin
      over = limit_enable_q && (sum >= {1'b0, byte_limit_q});
    end
  end

  always_comb begin
    priority if (halt_eff) begin
      status = ube_pkg::ST_STOPPED;
    end else if (code_point_i[31]) begin
      status = ube_pkg::ST_ILLEGAL;
    end else if (over) begin
      status = ube_pkg::ST_STOPPED;
    end else begin
      status = ube_pkg::ST_OK;
    end
  end

  always_comb begin
    count_d  = count_q;
    halted_d = halted_q;
    if (in_fire) begin
      if (status == ube_pkg::ST_OK) begin
        count_d  = sum[ube_pkg::CountW] ? '1 : sum[ube_pkg::CountW-1:0];
        halted_d = 1'b0;
      end else begin
        count_d  = cnt_base;
        halted_d = 1'b1;
      end
    end
  end

  assign push_o             = in_fire;
  assign push_desc_o.cp     = code_point_i[30:0];
  assign push_desc_o.len    = (status == ube_pkg::ST_OK) ? len : 3'd1;
  assign push_desc_o.status = status;
  assign push_desc_o.base   = cnt_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      halted_q       <= 1'b0;
      byte_limit_q   <= ube_pkg::BYTE_LIMIT_RST;
      limit_enable_q <= ube_pkg::LIMIT_ENABLE_RST;
    end else begin
      count_q  <= count_d;
      halted_q <= halted_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ube_pkg::REG_BYTE_LIMIT:   byte_limit_q   <= cfg_data_i;
          ube_pkg::REG_LIMIT_ENABLE: limit_enable_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  a_halt_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && status != ube_pkg::ST_OK |=> halted_q)
    else $error("front: failed character did not halt the string");

  a_count_holds_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && status != ube_pkg::ST_OK |=> count_q == $past(cnt_base))
    else $error("front: count changed on a failed character");

endmodule

// ===== rtl/ube_queue.sv =====
// ----------------------------------------------------------------------------
// ube_queue
// Short descriptor queue between the classifying front and the byte emitter.
// ----------------------------------------------------------------------------
module ube_queue #(
  parameter int Depth = ube_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ube_pkg::desc_t push_desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output ube_pkg::desc_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ube_pkg::desc_t mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue: push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue: pop from an empty queue");

endmodule

// ===== rtl/ube_back.sv =====
// ----------------------------------------------------------------------------
// ube_back
// Walks the descriptor at the queue head and emits its bytes one per cycle,
// while the receiver takes them, through an output register.
// ----------------------------------------------------------------------------
module ube_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  ube_pkg::desc_t             head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  output logic [1:0]                 status_o,
  output logic [ube_pkg::CountW-1:0] bytes_so_far_o
);

  logic [ube_pkg::LenW-1:0]   idx_q;
  logic                       out_valid_q;
  logic [7:0]                 byte_q;
  logic                       last_q;
  ube_pkg::status_e           status_q;
  logic [ube_pkg::CountW-1:0] cnt_q;

  logic                       load;
  logic                       is_last;
  logic                       is_ok;
  logic [ube_pkg::CountW:0]   sum;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.len - 3'd1);
  assign is_ok   = (head_i.status == ube_pkg::ST_OK);
  assign pop_o   = load && is_last;

  // Count after this byte, saturating at the top of the range.
  assign sum = {1'b0, head_i.base} + (ube_pkg::CountW + 1)'(idx_q) + 1'b1;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= is_ok ? ube_pkg::enc_byte(head_i.cp, head_i.len, idx_q) : 8'h00;
      last_q   <= is_last;
      status_q <= head_i.status;
      if (!is_ok) begin
        cnt_q <= head_i.base;
      end else begin
        cnt_q <= sum[ube_pkg::CountW] ? '1 : sum[ube_pkg::CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign last_of_run_o  = last_q;
  assign status_o       = status_q;
  assign bytes_so_far_o = cnt_q;

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i && !is_ok |-> head_i.len == 3'd1 && idx_q == '0)
    else $error("back: status descriptor is not a single result");

endmodule

// ===== rtl/utf8_encoder_with_byte_budget_top.sv =====
// ----------------------------------------------------------------------------
// utf8_encoder_with_byte_budget_top
// UTF-8 encoder (31-bit form, 1 to 6 bytes) with a per-string byte budget.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i/in_ready_o) takes one wide character per
// transaction; first_of_string_i clears the byte count and halt first. The
// output channel (out_valid_o/out_ready_i) gives one transaction per encoded
// byte, or a single status transaction for an illegal character, a budget
// overrun or a halted string; last_of_run_o marks the final one of a char.
// The config channel writes byte_limit (index 0) and limit_enable (index 1);
// it is always ready; the user must write it only while the block is idle,
// which the block itself leaves unenforced. The front classifies a character
// and updates the count in the cycle it is accepted, so a new character can
// be taken every cycle while the queue has room. The first byte passes
// through the queue and then the output register. The back emits one byte
// per cycle while the receiver is ready, so sustained rate is set by the
// total byte count of the stream. When the receiver stalls the output register
// holds, the queue fills, and in_ready_o drops. Reset clears the count, the
// halt flag and the queue, and restores byte_limit to all ones, limit enabled.
// ----------------------------------------------------------------------------
module utf8_encoder_with_byte_budget_top #(
  parameter int QueueDepth = ube_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ube_pkg::CpW-1:0]     code_point_i,
  input  logic                        first_of_string_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        last_of_run_o,
  output logic [1:0]                  status_o,
  output logic [ube_pkg::CountW-1:0]  bytes_so_far_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ube_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ube_pkg::CountW-1:0]  cfg_data_i
);

  logic           push;
  ube_pkg::desc_t push_desc;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  ube_pkg::desc_t head;

  ube_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .code_point_i      (code_point_i),
    .first_of_string_i (first_of_string_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .q_full_i          (q_full),
    .push_o            (push),
    .push_desc_o       (push_desc)
  );

  ube_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ube_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .status_o       (status_o),
    .bytes_so_far_o (bytes_so_far_o)
  );

endmodule
